>>> sv/sffd_pkg.sv
`timescale 1ns / 1ps

package sffd_pkg;

  localparam int HISTORY_DEPTH    = 8;
  localparam int HIST_IDX_W       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIGH_ID_MIN      = 128;
  localparam int HIGH_ID_MAX      = 199;
  localparam int LOW_ID_MIN       = 2000;
  localparam int LOW_ID_MAX       = 2031;
  localparam int LOW_CHANNEL_BASE = 100;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [1:0] CFG_OWN_NODE    = 2'd0;
  localparam logic [1:0] CFG_OWN_CHANNEL = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [7:0]  OWN_NODE_RST    = 8'd1;
  localparam logic [7:0]  OWN_CHANNEL_RST = 8'd0;
  localparam logic [31:0] TIMEOUT_RST     = 32'd100000;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_FOREIGN   = 2'd2,
    ST_REPEAT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic [31:0] header;
    logic [2:0]  iface;
    logic [63:0] arr_time;
    logic        is_request;
    logic [7:0]  channel;
    status_t     status;
  } item_t;

endpackage

>>> sv/sffd_front.sv
`timescale 1ns / 1ps

module sffd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [10:0]         in_message_id,
  input  logic [7:0]          in_sender_node,
  input  logic [31:0]         in_frame_header,
  input  logic [2:0]          in_interface_index,
  input  logic [63:0]         in_arrival_time,
  input  logic [7:0]          own_node_id,
  input  logic [7:0]          own_service_channel,
  output logic                q_valid,
  input  logic                q_ready,
  output sffd_pkg::item_t     q_item
);

  logic        vld_r;
  logic [10:0] id_r;
  logic [7:0]  sender_r;
  logic [31:0] header_r;
  logic [2:0]  iface_r;
  logic [63:0] time_r;

  logic signed [12:0] even_s;
  logic signed [12:0] ch_s;
  logic               in_range;
  logic               id_ok;
  logic [7:0]         chan;
  logic               req;
  logic               foreign;

  assign in_ready = !vld_r || q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id_r     <= in_message_id;
      sender_r <= in_sender_node;
      header_r <= in_frame_header;
      iface_r  <= in_interface_index;
      time_r   <= in_arrival_time;
    end
  end

  // id to channel and request flag
  always_comb begin
    even_s   = $signed({2'b00, id_r[10:1], 1'b0});
    ch_s     = '0;
    in_range = 1'b0;
    if (id_r >= 11'(sffd_pkg::HIGH_ID_MIN) && id_r <= 11'(sffd_pkg::HIGH_ID_MAX)) begin
      in_range = 1'b1;
      ch_s     = (even_s - 13'(sffd_pkg::HIGH_ID_MIN)) >>> 1;
    end else if (id_r >= 11'(sffd_pkg::LOW_ID_MIN) &&
                 id_r <= 11'(sffd_pkg::LOW_ID_MAX)) begin
      in_range = 1'b1;
      ch_s     = ((even_s - 13'(sffd_pkg::LOW_ID_MIN)) >>> 1) +
                 13'(sffd_pkg::LOW_CHANNEL_BASE);
    end
    id_ok = in_range && (ch_s >= 13'sd0) && (ch_s <= 13'sd255);
    chan  = id_ok ? ch_s[7:0] : 8'd0;
    req   = id_ok && !id_r[0];
    if (req) begin
      foreign = (sender_r != own_node_id) && (sender_r != 8'd0);
    end else begin
      foreign = (chan != own_service_channel) || (sender_r == own_node_id);
    end
  end

  always_comb begin
    q_valid           = vld_r;
    q_item.header     = header_r;
    q_item.iface      = iface_r;
    q_item.arr_time   = time_r;
    q_item.is_request = req;
    q_item.channel    = chan;
    priority if (!id_ok) begin
      q_item.status = sffd_pkg::ST_BAD_ID;
    end else if (foreign) begin
      q_item.status = sffd_pkg::ST_FOREIGN;
    end else begin
      q_item.status = sffd_pkg::ST_DELIVERED;
    end
  end

endmodule

>>> sv/sffd_fifo.sv
`timescale 1ns / 1ps

module sffd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sffd_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sffd_pkg::item_t rd_item
);

  sffd_pkg::item_t                 mem_r [sffd_pkg::Q_DEPTH];
  logic [sffd_pkg::Q_PTR_W-1:0]    wp_r;
  logic [sffd_pkg::Q_PTR_W-1:0]    rp_r;
  logic [sffd_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                            push;
  logic                            pop;

  assign wr_ready = (cnt_r != sffd_pkg::Q_CNT_W'(sffd_pkg::Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

>>> sv/sffd_back.sv
`timescale 1ns / 1ps

module sffd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  sffd_pkg::item_t q_item,
  input  logic [31:0]     repeat_timeout,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_deliver,
  output logic            out_is_request,
  output logic [7:0]      out_channel,
  output logic [1:0]      out_status
);

  sffd_pkg::bk_state_t state_r, state_nxt;

  logic [31:0] hist_hdr_r  [sffd_pkg::HISTORY_DEPTH];
  logic [7:0]  hist_mask_r [sffd_pkg::HISTORY_DEPTH];
  logic [63:0] hist_time_r [sffd_pkg::HISTORY_DEPTH];

  sffd_pkg::item_t                cur_r;
  sffd_pkg::status_t              st_r, st_nxt;
  logic [sffd_pkg::HIST_IDX_W-1:0] idx_r;
  logic [sffd_pkg::HIST_IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic [63:0]                    min_r, min_nxt;

  logic        out_valid_r;
  logic        deliver_r;
  logic        is_req_r;
  logic [7:0]  chan_r;
  logic [1:0]  status_r;

  logic [63:0] e_time;
  logic [63:0] age;
  logic [7:0]  bit_sel;
  logic        hit;
  logic        out_free;
  logic        take;
  logic        load_out;
  logic        set_mask;
  logic        wr_entry;

  assign out_free = !out_valid_r || out_ready;
  assign bit_sel  = 8'(1) << cur_r.iface;
  assign e_time   = hist_time_r[idx_r];
  assign age      = cur_r.arr_time - e_time;
  assign hit      = (e_time != 64'd0) && (hist_hdr_r[idx_r] == cur_r.header) &&
                    (age <= {32'd0, repeat_timeout}) &&
                    ((hist_mask_r[idx_r] & bit_sel) == 8'd0);

  // oldest entry: strict less, so ties keep the lower index
  always_comb begin
    min_nxt     = min_r;
    old_idx_nxt = old_idx_r;
    if (idx_r == '0 || e_time < min_r) begin
      min_nxt     = e_time;
      old_idx_nxt = idx_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sffd_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.status == sffd_pkg::ST_DELIVERED) ? sffd_pkg::BK_SCAN :
                                                                   sffd_pkg::BK_DONE;
        end
      end
      sffd_pkg::BK_SCAN: begin
        if (hit || idx_r == sffd_pkg::HIST_IDX_W'(sffd_pkg::HISTORY_DEPTH - 1)) begin
          state_nxt = sffd_pkg::BK_DONE;
        end
      end
      sffd_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = sffd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sffd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    set_mask = 1'b0;
    load_out = 1'b0;
    wr_entry = 1'b0;
    st_nxt   = st_r;
    unique case (state_r)
      sffd_pkg::BK_IDLE: begin
        take   = q_valid;
        st_nxt = q_item.status;
      end
      sffd_pkg::BK_SCAN: begin
        set_mask = hit;
        if (hit) begin
          st_nxt = sffd_pkg::ST_REPEAT;
        end
      end
      sffd_pkg::BK_DONE: begin
        load_out = out_free;
        wr_entry = out_free && (st_r == sffd_pkg::ST_DELIVERED);
      end
      default: ;
    endcase
  end

  assign q_ready = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sffd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (take) begin
      cur_r <= q_item;
      idx_r <= '0;
    end else if (state_r == sffd_pkg::BK_SCAN) begin
      idx_r     <= idx_r + 1'b1;
      min_r     <= min_nxt;
      old_idx_r <= old_idx_nxt;
    end
    if (load_out) begin
      deliver_r <= (st_r == sffd_pkg::ST_DELIVERED);
      is_req_r  <= cur_r.is_request;
      chan_r    <= cur_r.channel;
      status_r  <= st_r;
    end
  end

  // an empty entry is marked by a zero time, so only the times need clearing
  always_ff @(posedge clk) begin
    for (int i = 0; i < sffd_pkg::HISTORY_DEPTH; i++) begin
      if (!rst_n) begin
        hist_time_r[i] <= 64'd0;
      end else if (wr_entry && old_idx_r == sffd_pkg::HIST_IDX_W'(i)) begin
        hist_time_r[i] <= cur_r.arr_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sffd_pkg::HISTORY_DEPTH; i++) begin
      if (wr_entry && old_idx_r == sffd_pkg::HIST_IDX_W'(i)) begin
        hist_hdr_r[i]  <= cur_r.header;
        hist_mask_r[i] <= bit_sel;
      end else if (set_mask && idx_r == sffd_pkg::HIST_IDX_W'(i)) begin
        hist_mask_r[i] <= hist_mask_r[i] | bit_sel;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_deliver    = deliver_r;
  assign out_is_request = is_req_r;
  assign out_channel    = chan_r;
  assign out_status     = status_r;

endmodule

>>> sv/service_frame_filter_dedup_core.sv
`timescale 1ns / 1ps
// Redundant service-frame filter for one node-service subscription.
// Input channel (in_*): one received frame per word: message id, sender node,
// first four payload bytes, interface index and arrival time.
// Output channel (out_*): exactly one result word per input word, in order:
// deliver flag, request flag, decoded channel and status.
// Config channel (cfg_*): index 0 own node id, 1 own service channel,
// 2 repeat timeout; always ready, write only while the block is idle.
// A front stage decodes and filters each word and queues it (two words deep);
// the back end walks the eight-entry history one entry per cycle.
// Path: a frame that reaches the history walk passes the front stage, the
// queue, a walk of up to eight entries (a hit ends it early) and the done
// state, which loads the result register; a bad id or foreign frame skips the walk.
// The back end takes a new frame only after the last one has left for the
// result register, so the history walk limits how fast checked frames pass.
// Reset (synchronous, rst_n low) empties the history, the queue and the output
// register and restores the register defaults.
// When out_ready is low the result is held; the queue and front stage keep
// taking words until they fill, then in_ready drops.
module service_frame_filter_dedup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] in_message_id,
  input  logic [7:0]  in_sender_node,
  input  logic [31:0] in_frame_header,
  input  logic [2:0]  in_interface_index,
  input  logic [63:0] in_arrival_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_deliver,
  output logic        out_is_request,
  output logic [7:0]  out_channel,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]  own_node_r;
  logic [7:0]  own_chan_r;
  logic [31:0] timeout_r;

  logic            fq_valid, fq_ready;
  sffd_pkg::item_t fq_item;
  logic            qb_valid, qb_ready;
  sffd_pkg::item_t qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r <= sffd_pkg::OWN_NODE_RST;
      own_chan_r <= sffd_pkg::OWN_CHANNEL_RST;
      timeout_r  <= sffd_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sffd_pkg::CFG_OWN_NODE:    own_node_r <= cfg_data[7:0];
        sffd_pkg::CFG_OWN_CHANNEL: own_chan_r <= cfg_data[7:0];
        sffd_pkg::CFG_TIMEOUT:     timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sffd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_message_id       (in_message_id),
    .in_sender_node      (in_sender_node),
    .in_frame_header     (in_frame_header),
    .in_interface_index  (in_interface_index),
    .in_arrival_time     (in_arrival_time),
    .own_node_id         (own_node_r),
    .own_service_channel (own_chan_r),
    .q_valid             (fq_valid),
    .q_ready             (fq_ready),
    .q_item              (fq_item)
  );

  sffd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  sffd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (qb_valid),
    .q_ready        (qb_ready),
    .q_item         (qb_item),
    .repeat_timeout (timeout_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_deliver    (out_deliver),
    .out_is_request (out_is_request),
    .out_channel    (out_channel),
    .out_status     (out_status)
  );

endmodule

>>> sv/sffd_checker.sv
`timescale 1ns / 1ps

module sffd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_deliver,
  input logic        out_is_request,
  input logic [7:0]  out_channel,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_channel) && $stable(out_deliver) && $stable(out_is_request))
    else $error("result word changed while stalled");

  a_deliver_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_deliver == (out_status == sffd_pkg::ST_DELIVERED))
    else $error("deliver flag disagrees with status");

  a_bad_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sffd_pkg::ST_BAD_ID |->
      !out_is_request && out_channel == 8'd0)
    else $error("bad id word carries decoded fields");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sffd_pkg::ST_BAD_ID |->
      out_channel <= 8'((sffd_pkg::HIGH_ID_MAX - sffd_pkg::HIGH_ID_MIN) / 2) ||
      (out_channel >= 8'(sffd_pkg::LOW_CHANNEL_BASE) &&
       out_channel <= 8'((sffd_pkg::LOW_ID_MAX - sffd_pkg::LOW_ID_MIN) / 2 +
                         sffd_pkg::LOW_CHANNEL_BASE)))
    else $error("decoded channel outside both id ranges");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind service_frame_filter_dedup_core sffd_checker u_sffd_checker (.*);
